[design/linear_feather_seam_blend_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seam blend block
// Concurrent assertion wrappers on clk, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef LINEAR_FEATHER_SEAM_BLEND_TOP_DEFINES_SVH
`define LINEAR_FEATHER_SEAM_BLEND_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked out of reset only
`define LFSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define LFSB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFSB_ASSERT(label, prop, msg)
`define LFSB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[design/lfsb_pkg.sv]
// ----------------------------------------------------------------------------
// lfsb_pkg
// Types and constants shared by the seam blend modules.
// ----------------------------------------------------------------------------
package lfsb_pkg;

    localparam int COL_W    = 12;
    localparam int OVW_W    = 13;
    localparam int PIX_W    = 8;
    localparam int NUM_W    = 20;   // 255 * 4096 fits
    localparam int RECIP_W  = 32;
    localparam int RECIP_SHIFT = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [OVW_W-1:0] MAX_WIDTH = 13'd4096;
    // floor(2^31 / 1), reciprocal for the reset width
    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_START_COLUMN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_WIDTH = 2'd1;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] left_blue;
        logic [PIX_W-1:0] left_green;
        logic [PIX_W-1:0] left_red;
        logic [PIX_W-1:0] warped_blue;
        logic [PIX_W-1:0] warped_green;
        logic [PIX_W-1:0] warped_red;
    } lfsb_pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic             in_overlap;
    } lfsb_res_t;

    typedef struct packed {
        logic             start;
        logic [OVW_W-1:0] divisor;
    } lfsb_recip_req_t;

    typedef logic [2:0][PIX_W-1:0] lfsb_rgb_t;

endpackage

[design/lfsb_recip.sv]
// ----------------------------------------------------------------------------
// lfsb_recip
// Restoring divider: floor(2^31 / divisor), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfsb_recip
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfsb_pkg::lfsb_recip_req_t           req,
    output logic                                busy,
    output logic [lfsb_pkg::RECIP_W-1:0]        recip
);

    localparam int CNT_W = $clog2(lfsb_pkg::RECIP_W);

    logic                           busy_reg,  busy_next;
    logic [CNT_W-1:0]               cnt_reg,   cnt_next;
    logic [lfsb_pkg::OVW_W-1:0]     rem_reg,   rem_next;
    logic [lfsb_pkg::OVW_W-1:0]     div_reg,   div_next;
    logic [lfsb_pkg::RECIP_W-1:0]   quot_reg,  quot_next;
    logic [lfsb_pkg::OVW_W:0]       rem_shift;
    logic                           dbit;
    logic                           ge;

    always_comb
    begin
        // dividend is a single one in its top bit
        dbit      = (cnt_reg == CNT_W'(lfsb_pkg::RECIP_W - 1));
        rem_shift = {rem_reg, dbit};
        ge        = (rem_shift >= {1'b0, div_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(lfsb_pkg::RECIP_W - 1);
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? lfsb_pkg::OVW_W'(rem_shift - {1'b0, div_reg})
                           : rem_shift[lfsb_pkg::OVW_W-1:0];
            quot_next = {quot_reg[lfsb_pkg::RECIP_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= lfsb_pkg::OVW_W'(1);
            quot_reg <= lfsb_pkg::RECIP_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            quot_reg <= quot_next;
        end
    end

    assign busy  = busy_reg;
    assign recip = quot_reg;

endmodule

[design/linear_feather_seam_blend_top.sv]
// ----------------------------------------------------------------------------
// linear_feather_seam_blend_top
// Linear feather blend of left and warped pixels across a stitching seam.
// ----------------------------------------------------------------------------
// Usage:
//   pix channel (pix_valid / pix_stall / pix): one item per pixel, carrying
//   its column and the left and warped BGR values. res channel (res_valid /
//   res_stall / res): one item back per pixel, in order, with the output
//   BGR value and the in_overlap flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
//   start_column, index 1 sets overlap_width; other indexes are dropped.
//   Throughput is one item per cycle while pix_stall is low. Four register
//   stages (decode, weighted sum, reciprocal multiply, quotient correction).
//   The division by the overlap width is a multiply by a stored
//   reciprocal; writing overlap_width reruns a bit-serial divider, and
//   while it runs cfg_ready is low and pix_stall high.
//   Reset clears all valid bits and loads start 0, width 1 with its
//   reciprocal ready, so items are taken straight after reset.
//   A stall on res holds the output item; bubbles inside the pipe still
//   close up, and pix_stall rises once every stage is full.
// ----------------------------------------------------------------------------
`include "linear_feather_seam_blend_top_defines.svh"

module linear_feather_seam_blend_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  lfsb_pkg::lfsb_pix_t                 pix,
    output logic                                res_valid,
    input  logic                                res_stall,
    output lfsb_pkg::lfsb_res_t                 res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfsb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lfsb_pkg::OVW_W-1:0]          cfg_data
);

    localparam int CW = lfsb_pkg::COL_W;
    localparam int WW = lfsb_pkg::OVW_W;
    localparam int PW = lfsb_pkg::PIX_W;
    localparam int NW = lfsb_pkg::NUM_W;
    localparam int RW = lfsb_pkg::RECIP_W;
    localparam int PRODW = NW + RW;

    // ------------------------------------------------------------------
    // Configuration registers and reciprocal of the effective width
    // ------------------------------------------------------------------
    logic [CW-1:0]              start_reg,  start_next;
    logic [WW-1:0]              width_reg,  width_next;
    logic [WW-1:0]              width_clamp;
    lfsb_pkg::lfsb_recip_req_t  recip_req;
    logic                       recip_busy;
    logic [RW-1:0]              recip;
    logic                       cfg_write;

    assign cfg_ready = !recip_busy;
    assign cfg_write = cfg_valid && cfg_ready;

    // Saturate the width before it is stored, so the pipe sees it final
    assign width_clamp = (cfg_data > lfsb_pkg::MAX_WIDTH) ? lfsb_pkg::MAX_WIDTH : cfg_data;

    always_comb
    begin
        start_next        = start_reg;
        width_next        = width_reg;
        recip_req.start   = 1'b0;
        recip_req.divisor = width_clamp;
        if (cfg_write)
        begin
            unique case (cfg_index)
                lfsb_pkg::CFG_START_COLUMN:
                begin
                    start_next = cfg_data[CW-1:0];
                end
                lfsb_pkg::CFG_OVERLAP_WIDTH:
                begin
                    width_next      = width_clamp;
                    recip_req.start = 1'b1;
                end
                default:
                begin
                    // unknown register: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            width_reg <= WW'(1);
        end
        else
        begin
            start_reg <= start_next;
            width_reg <= width_next;
        end
    end

    lfsb_recip u_recip
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (recip_req),
        .busy  (recip_busy),
        .recip (recip)
    );

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when empty or when
    // the stage after it moves on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, res_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic pix_accept;

    assign rdy4 = !res_valid_reg || !res_stall;
    assign rdy3 = !s3_valid_reg  || rdy4;
    assign rdy2 = !s2_valid_reg  || rdy3;
    assign rdy1 = !s1_valid_reg  || rdy2;

    // Hold the input off while the reciprocal is being rebuilt
    assign pix_stall  = !rdy1 || recip_busy;
    assign pix_accept = pix_valid && !pix_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= pix_accept;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: overlap decode and blend weights
    // ------------------------------------------------------------------
    logic [CW:0]            diff;
    logic [CW-1:0]          k_c;
    logic [WW-1:0]          wk_c;
    logic                   inside_c;
    logic                   pass_c;
    lfsb_pkg::lfsb_rgb_t    left_c, warped_c;

    always_comb
    begin
        left_c   = {pix.left_red, pix.left_green, pix.left_blue};
        warped_c = {pix.warped_red, pix.warped_green, pix.warped_blue};
        // top bit of the difference is the borrow: column below start
        diff     = {1'b0, pix.column} - {1'b0, start_reg};
        k_c      = diff[CW-1:0];
        inside_c = (width_reg != '0) && !diff[CW] && ({1'b0, k_c} < width_reg);
        wk_c     = width_reg - {1'b0, k_c};
        // no warped data, or outside the overlap: the left pixel passes
        pass_c   = !inside_c || (warped_c == '0);
    end

    logic [CW-1:0]          s1_k_reg;
    logic [WW-1:0]          s1_wk_reg;
    logic                   s1_inside_reg, s1_pass_reg;
    lfsb_pkg::lfsb_rgb_t    s1_left_reg, s1_warped_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && pix_accept)
        begin
            s1_k_reg      <= k_c;
            s1_wk_reg     <= wk_c;
            s1_inside_reg <= inside_c;
            s1_pass_reg   <= pass_c;
            s1_left_reg   <= left_c;
            s1_warped_reg <= warped_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted sum left*(W-k) + warped*k per channel
    // ------------------------------------------------------------------
    logic [2:0][NW-1:0]     num_c;
    logic [NW:0]            prod_l, prod_w;

    always_comb
    begin
        prod_l = '0;
        prod_w = '0;
        for (int c = 0; c < 3; c++)
        begin
            prod_l   = (NW+1)'(s1_left_reg[c]) * (NW+1)'(s1_wk_reg);
            prod_w   = (NW+1)'(s1_warped_reg[c]) * (NW+1)'(s1_k_reg);
            num_c[c] = NW'(prod_l + prod_w);
        end
    end

    logic [2:0][NW-1:0]     s2_num_reg;
    logic                   s2_inside_reg, s2_pass_reg;
    lfsb_pkg::lfsb_rgb_t    s2_left_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            s2_num_reg    <= num_c;
            s2_inside_reg <= s1_inside_reg;
            s2_pass_reg   <= s1_pass_reg;
            s2_left_reg   <= s1_left_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate num * floor(2^31 / W) >> 31, low by at
    // most one
    // ------------------------------------------------------------------
    logic [2:0][PW-1:0]     qest_c;
    logic [PRODW-1:0]       prod_r;

    always_comb
    begin
        prod_r = '0;
        for (int c = 0; c < 3; c++)
        begin
            prod_r    = PRODW'(s2_num_reg[c]) * PRODW'(recip);
            qest_c[c] = prod_r[lfsb_pkg::RECIP_SHIFT + PW - 1 : lfsb_pkg::RECIP_SHIFT];
        end
    end

    logic [2:0][PW-1:0]     s3_qest_reg;
    logic [2:0][NW-1:0]     s3_num_reg;
    logic                   s3_inside_reg, s3_pass_reg;
    lfsb_pkg::lfsb_rgb_t    s3_left_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            s3_qest_reg   <= qest_c;
            s3_num_reg    <= s2_num_reg;
            s3_inside_reg <= s2_inside_reg;
            s3_pass_reg   <= s2_pass_reg;
            s3_left_reg   <= s2_left_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the estimate by one where the remainder reaches W,
    // then pick blended or left pixel
    // ------------------------------------------------------------------
    lfsb_pkg::lfsb_rgb_t    q_c;
    lfsb_pkg::lfsb_rgb_t    out_c;
    logic [NW:0]            qw, rem;

    always_comb
    begin
        qw  = '0;
        rem = '0;
        for (int c = 0; c < 3; c++)
        begin
            qw     = (NW+1)'(s3_qest_reg[c]) * (NW+1)'(width_reg);
            rem    = {1'b0, s3_num_reg[c]} - qw;
            q_c[c] = s3_qest_reg[c] + PW'(rem >= (NW+1)'(width_reg));
        end
        out_c = s3_pass_reg ? s3_left_reg : q_c;
    end

    lfsb_pkg::lfsb_res_t    res_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_valid_reg)
        begin
            res_reg.out_blue   <= out_c[0];
            res_reg.out_green  <= out_c[1];
            res_reg.out_red    <= out_c[2];
            res_reg.in_overlap <= s3_inside_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LFSB_ASSERT(a_no_take_while_recip, pix_valid && recip_busy |-> pix_stall, "item taken during reciprocal update")
    `LFSB_ASSERT(a_width_starts_recip, cfg_write && (cfg_index == lfsb_pkg::CFG_OVERLAP_WIDTH) |=> recip_busy, "width write did not start reciprocal")
    `LFSB_ASSERT(a_s3_holds, s3_valid_reg && !rdy4 |=> s3_valid_reg && $stable(s3_num_reg), "stage 3 lost its item under stall")
    `LFSB_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !res_valid_reg && !s1_valid_reg, "pipe not empty in reset")

endmodule

[dv/tb_linear_feather_seam_blend_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_feather_seam_blend_top
// Self-checking bench for the seam feather blend: a directed table of
// register writes and pixels, then random pixels around random overlaps,
// each result checked in order against a local integer predictor or typed value.
// ----------------------------------------------------------------------------
module tb_linear_feather_seam_blend_top;

    import lfsb_pkg::*;

    // Indexes past the two registers; the block must drop writes to them
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 2'd3;

    localparam int SEGMENTS     = 14;
    localparam int SEG_ITEMS    = 100;
    localparam int STUCK_LIMIT  = 4000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 8;      // pipe is four deep
    localparam int HOLD_AT      = 1200;   // results seen when the long hold starts
    localparam int HOLD_CYCLES  = 120;

    typedef enum bit { ROW_REG, ROW_PIX } row_kind_t;

    // One line of the directed table: a register write or a pixel, the
    // latter optionally with its result typed in by hand
    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [OVW_W-1:0]       data;
        lfsb_pix_t              pix;
        bit                     typed;
        lfsb_res_t              want;
    } seam_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b1;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    lfsb_pix_t              pix = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    lfsb_res_t              res;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [OVW_W-1:0]       cfg_data = '0;

    // Local copy of the two registers, as the block should hold them
    logic [COL_W-1:0]       seam_start = '0;
    logic [OVW_W-1:0]       seam_width = 13'd1;

    lfsb_res_t              blend_due[$];     // results still owed, oldest first
    int                     mismatches = 0;
    int                     blends_checked = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_left = 0;
    bit                     hold_done = 1'b0;
    bit                     cfg_open = 1'b0;  // cfg_valid left high by the last write
    int                     stuck_cycles = 0;

    linear_feather_seam_blend_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor((left*(w-k) + warped*k) / w), exact; numerator stays under 2^20
    function automatic logic [PIX_W-1:0] mix_channel(input logic [PIX_W-1:0] left_v,
                                                     input logic [PIX_W-1:0] warped_v,
                                                     input int unsigned k,
                                                     input int unsigned w);
        int unsigned num;
        int unsigned quo;
        num = int'(left_v) * (w - k) + int'(warped_v) * k;
        quo = num / w;
        return quo[PIX_W-1:0];
    endfunction

    function automatic lfsb_res_t feather_blend(input lfsb_pix_t p);
        lfsb_res_t      r;
        int unsigned    w;
        int unsigned    k;
        bit             in_ovl;
        // Saturate the width; zero leaves the overlap empty
        w = (seam_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(seam_width);
        in_ovl = (w != 0) && (p.column >= seam_start);
        k = int'(p.column) - int'(seam_start);
        in_ovl = in_ovl && (k < w);
        r.out_blue   = p.left_blue;
        r.out_green  = p.left_green;
        r.out_red    = p.left_red;
        r.in_overlap = in_ovl;
        // An all-zero warped pixel means no warped data: keep the left one
        if (in_ovl && {p.warped_blue, p.warped_green, p.warped_red} != '0)
        begin
            r.out_blue  = mix_channel(p.left_blue,  p.warped_blue,  k, w);
            r.out_green = mix_channel(p.left_green, p.warped_green, k, w);
            r.out_red   = mix_channel(p.left_red,   p.warped_red,   k, w);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic seam_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [OVW_W-1:0] data);
        seam_row_t r;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.data  = data;
        r.pix   = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // Pixel checked against the predictor
    function automatic seam_row_t pix_row(input logic [COL_W-1:0] col,
                                          input logic [23:0] left_bgr,
                                          input logic [23:0] warped_bgr);
        seam_row_t r;
        r.kind  = ROW_PIX;
        r.idx   = '0;
        r.data  = '0;
        r.pix   = {col, left_bgr, warped_bgr};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // Pixel with its result written out by hand
    function automatic seam_row_t pix_row_exp(input logic [COL_W-1:0] col,
                                              input logic [23:0] left_bgr,
                                              input logic [23:0] warped_bgr,
                                              input lfsb_res_t want);
        seam_row_t r;
        r = pix_row(col, left_bgr, warped_bgr);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Aim most columns at the overlap and a couple either side of it
    function automatic lfsb_pix_t random_pixel();
        lfsb_pix_t  p;
        int         span;
        int         col;
        span = (seam_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(seam_width);
        if ($urandom_range(0, 3) == 0)
            col = $urandom_range(0, 4095);
        else
            col = int'(seam_start) + int'($urandom_range(0, span + 3)) - 2;
        if (col < 0)
            col = 0;
        if (col > 4095)
            col = 4095;
        p.column = col[COL_W-1:0];
        {p.left_blue, p.left_green, p.left_red} = 24'($urandom);
        if ($urandom_range(0, 7) == 0)
            {p.warped_blue, p.warped_green, p.warped_red} = '0;
        else
            {p.warped_blue, p.warped_green, p.warped_red} = 24'($urandom);
        return p;
    endfunction

    function automatic logic [OVW_W-1:0] random_width();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return MAX_WIDTH;
            2:       return OVW_W'($urandom_range(4097, 8191));
            3:       return 13'd1;
            4, 5:    return OVW_W'($urandom_range(1, 4096));
            default: return OVW_W'($urandom_range(2, 64));
        endcase
    endfunction

    function automatic logic [OVW_W-1:0] random_start();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 13'h1fff;
            2:       return OVW_W'($urandom_range(3900, 4095));
            default: return OVW_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Drop the write channel if the last write left it open
    task automatic close_cfg();
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (blend_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one register with the pipe empty; leave cfg_valid high so that
    // back-to-back writes need no extra step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OVW_W-1:0] data);
        wait_drained();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        cfg_open = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_START_COLUMN:  seam_start = data[COL_W-1:0];
            CFG_OVERLAP_WIDTH: seam_width = data;
            default:           ;
        endcase
    endtask

    // Offer one item, idling first at the current rate; log the owed result
    // at the accepting edge
    task automatic offer_pixel(input lfsb_pix_t p, input bit typed, input lfsb_res_t want);
        close_cfg();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix       <= p;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
        blend_due = {blend_due, (typed ? want : feather_blend(p))};
    endtask

    // ------------------------------------------------------------------
    // Receiver: check each accepted result, then pick the next stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lfsb_res_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (blend_due.size() == 0)
                begin
                    mismatches++;
                    $display("%t: result with nothing owed, got %h %h %h ovl=%b",
                             $time, res.out_blue, res.out_green, res.out_red,
                             res.in_overlap);
                end
                else
                begin
                    want = blend_due.pop_front();
                    blends_checked++;
                    if (res.out_blue !== want.out_blue || res.out_green !== want.out_green ||
                        res.out_red !== want.out_red || res.in_overlap !== want.in_overlap)
                    begin
                        mismatches++;
                        $display("%t: mismatch exp %h %h %h ovl=%b got %h %h %h ovl=%b",
                                 $time, want.out_blue, want.out_green, want.out_red,
                                 want.in_overlap, res.out_blue, res.out_green,
                                 res.out_red, res.in_overlap);
                    end
                end
            end
            // One long hold mid-run so the pipe backs up into pix_stall
            if (!hold_done && blends_checked == HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which no channel moves anything
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_valid && !pix_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        seam_row_t  dir_rows[$];
        seam_row_t  row;
        int         seg;
        int         n;

        // Assert reset with a real falling edge once every process waits
        rst_n <= 1'b0;

        // Reset state: start 0, width 1, so column 0 alone is in the overlap
        dir_rows = '{
            pix_row_exp(12'd0,   24'h000000, 24'hffffff, {24'h000000, 1'b1}),
            pix_row_exp(12'd0,   24'hffffff, 24'hffffff, {24'hffffff, 1'b1}),
            pix_row_exp(12'd0,   24'h123456, 24'h000000, {24'h123456, 1'b1}),
            pix_row_exp(12'd1,   24'ha55ac3, 24'hffffff, {24'ha55ac3, 1'b0}),
            pix_row_exp(12'hfff, 24'hffffff, 24'h010101, {24'hffffff, 1'b0}),
            // Zero width: nothing blends
            reg_row(CFG_OVERLAP_WIDTH, 13'd0),
            pix_row_exp(12'd0,   24'h80ff01, 24'hffffff, {24'h80ff01, 1'b0}),
            // Writes to spare indexes must not touch either register
            reg_row(IDX_SPARE_A, 13'h1fff),
            reg_row(IDX_SPARE_B, 13'h1fff),
            pix_row_exp(12'd0,   24'h5a5a5a, 24'h0f0f0f, {24'h5a5a5a, 1'b0}),
            // Oversized width saturates, overlap runs off the last column
            reg_row(CFG_START_COLUMN, 13'd4000),
            reg_row(CFG_OVERLAP_WIDTH, 13'h1fff),
            pix_row_exp(12'd3999, 24'hffffff, 24'hffffff, {24'hffffff, 1'b0}),
            pix_row(12'd4000, 24'h000000, 24'hffffff),
            pix_row(12'hfff,  24'h000000, 24'hffffff),
            pix_row_exp(12'hfff, 24'h00ff7f, 24'h000000, {24'h00ff7f, 1'b1}),
            // Full width from column 0: deepest weights
            reg_row(CFG_START_COLUMN, 13'd0),
            reg_row(CFG_OVERLAP_WIDTH, MAX_WIDTH),
            pix_row(12'hfff,  24'h000000, 24'hffffff),
            pix_row(12'hfff,  24'hffffff, 24'h000001),
            pix_row(12'd2048, 24'hffffff, 24'hffffff),
            pix_row(12'd2048, 24'h0f0f0f, 24'hf0f0f0),
            // Top bit of the start write is dropped: start lands on 4095
            reg_row(CFG_START_COLUMN, 13'h1fff),
            reg_row(CFG_OVERLAP_WIDTH, 13'd1),
            pix_row_exp(12'hfff, 24'h7f7f7f, 24'h808080, {24'h7f7f7f, 1'b1}),
            pix_row_exp(12'hffe, 24'h7f7f7f, 24'h808080, {24'h7f7f7f, 1'b0}),
            // Narrow overlap, both edges
            reg_row(CFG_START_COLUMN, 13'd100),
            reg_row(CFG_OVERLAP_WIDTH, 13'd3),
            pix_row(12'd100, 24'hc80032, 24'h32c800),
            pix_row(12'd101, 24'hc80032, 24'h32c800),
            pix_row(12'd102, 24'hc80032, 24'h32c800),
            pix_row_exp(12'd103, 24'hc80032, 24'h32c800, {24'hc80032, 1'b0})
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, sender and receiver both eager
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.idx, row.data);
            else
                offer_pixel(row.pix, row.typed, row.want);
        end

        // Random segments, each under a fresh overlap setting
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 5)
            begin
                send_idle_pct  = 33;
                recv_stall_pct = 49;
            end
            else if (seg < 10)
            begin
                send_idle_pct  = 49;
                recv_stall_pct = 33;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B,
                          OVW_W'($urandom_range(0, 8191)));
            write_reg(CFG_START_COLUMN, random_start());
            write_reg(CFG_OVERLAP_WIDTH, random_width());
            for (n = 0; n < SEG_ITEMS; n++)
            begin
                // Pause the sender mid-segment until the pipe has emptied
                if (seg == 3 && n == SEG_ITEMS / 2)
                    wait_drained();
                offer_pixel(random_pixel(), 1'b0, '0);
            end
        end

        pix_valid <= 1'b0;
        close_cfg();
        while (blend_due.size() != 0)
            @(posedge clk);
        // Catch any stray result after the last one owed
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
